// File: rtl/u8ae_pkg.sv
// Shared types, codes and helper functions for the UTF-8 append encoder.
package u8ae_pkg;

    localparam int unsigned FIFO_DEPTH = 4;

    localparam logic [1:0] CMD_BEGIN  = 2'd0;
    localparam logic [1:0] CMD_ENCODE = 2'd1;
    localparam logic [1:0] CMD_END    = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_TRUNC  = 2'd1;
    localparam logic [1:0] ST_NOT_CP = 2'd2;

    typedef struct packed {
        logic [30:0] cp;
        logic [2:0]  n;
        logic [15:0] addr;
        logic        valid;
        logic [1:0]  status;
    } t_desc;

    function automatic logic [2:0] f_byte_count(input logic [30:0] cp);
        logic [2:0] n;
        if (cp <= 31'h7f) begin
            n = 3'd1;
        end else if (cp <= 31'h7ff) begin
            n = 3'd2;
        end else if (cp <= 31'hffff) begin
            n = 3'd3;
        end else if (cp <= 31'h1fffff) begin
            n = 3'd4;
        end else if (cp <= 31'h3ffffff) begin
            n = 3'd5;
        end else begin
            n = 3'd6;
        end
        return n;
    endfunction

    function automatic logic [7:0] f_lead(input logic [2:0] n);
        logic [7:0] lead;
        case (n)
            3'd2:    lead = 8'hc0;
            3'd3:    lead = 8'he0;
            3'd4:    lead = 8'hf0;
            3'd5:    lead = 8'hf8;
            3'd6:    lead = 8'hfc;
            default: lead = 8'h00;
        endcase
        return lead;
    endfunction

endpackage

// File: rtl/utf8_append_encoder.sv
// Top level of the UTF-8 append encoder: front end, job queue and byte emitter.
// Usage:
// The slave stream takes one command per beat: tuser holds the command
// (begin, encode, end), tdata holds the code point and the existing length.
// Begin sets the write position and gives no output. Encode yields one to six
// byte beats with buffer addresses, or one status-only beat when the value is
// not a code point or does not fit, and nothing after a truncation until the
// next begin or end. End yields the terminating zero with the sticky status.
// tlast marks the final beat of each command. The configuration channel
// writes the buffer size; it is always ready. The user must see that it is
// written only while the block is idle; the block itself does not enforce
// this. Jobs pass through the job queue to a registered output beat. The
// input side takes one command per cycle while the job queue has room; the
// output side moves one byte per cycle while the receiver is ready, and the
// queue absorbs the difference. Reset sets the buffer size to 65535 and
// clears position and status. When the receiver stalls, the output register
// holds its beat, the queue fills and tready drops only when the queue is full.
module utf8_append_encoder import u8ae_pkg::*; #(
    parameter int unsigned DEPTH = FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,      // buffer_size
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,  // code_point, existing_length
    input  logic [1:0]  i_s_axis_tuser,  // command
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // byte_value, byte_address
    output logic [2:0]  o_m_axis_tuser,  // byte_valid, status
    output logic        o_m_axis_tlast
);

    t_desc      w_push_desc;
    t_desc      w_head_desc;
    logic       w_push;
    logic       w_pop;
    logic       w_full;
    logic       w_empty;
    logic [7:0] w_value;
    logic [15:0] w_addr;
    logic       w_bv;
    logic [1:0] w_st;

    assign o_cfg_ready = 1'b1;

    u8ae_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_size (i_cfg_data),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_cmd      (i_s_axis_tuser),
        .i_cp       (i_s_axis_tdata[31:0]),
        .i_len      (i_s_axis_tdata[47:32]),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_desc     (w_push_desc)
    );

    u8ae_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_desc  (w_push_desc),
        .i_pop   (w_pop),
        .o_desc  (w_head_desc),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    u8ae_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc       (w_head_desc),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_value      (w_value),
        .o_addr       (w_addr),
        .o_byte_valid (w_bv),
        .o_status     (w_st),
        .o_last       (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {w_addr, w_value};
    assign o_m_axis_tuser = {w_st, w_bv};

endmodule

// File: rtl/u8ae_front.sv
// Front end: accepts commands, tracks the string state and queues byte jobs.
module u8ae_front import u8ae_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_size,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_cp,
    input  logic [15:0] i_len,
    input  logic        i_full,
    output logic        o_push,
    output t_desc       o_desc
);

    logic [15:0] r_size, n_size;
    logic [15:0] r_pos, n_pos;
    logic        r_stopped, n_stopped;
    logic [1:0]  r_sticky, n_sticky;

    logic [15:0] w_size;
    logic [15:0] w_sm1;
    logic [15:0] w_room;
    logic [15:0] w_clip_pos;
    logic [2:0]  w_n;
    logic        w_acc;

    assign o_ready = !i_full;
    assign w_acc   = i_valid && !i_full;

    assign w_size     = (r_size == 16'd0) ? 16'd1 : r_size;
    assign w_sm1      = w_size - 16'd1;
    assign w_room     = (r_pos < w_sm1) ? (w_sm1 - r_pos) : 16'd0;
    assign w_clip_pos = (r_pos > w_sm1) ? w_sm1 : r_pos;
    assign w_n        = f_byte_count(i_cp[30:0]);

    always_comb begin
        n_size    = i_cfg_we ? i_cfg_size : r_size;
        n_pos     = r_pos;
        n_stopped = r_stopped;
        n_sticky  = r_sticky;
        o_push    = 1'b0;
        o_desc    = '0;
        o_desc.n  = 3'd1;
        if (w_acc) begin
            case (i_cmd)
                CMD_BEGIN: begin
                    n_pos     = (i_len > w_sm1) ? w_sm1 : i_len;
                    n_stopped = 1'b0;
                    n_sticky  = ST_OK;
                end
                CMD_ENCODE: begin
                    if (!r_stopped) begin
                        o_push = 1'b1;
                        if (i_cp[31]) begin
                            n_sticky      = ST_NOT_CP;
                            o_desc.status = ST_NOT_CP;
                        end else if (w_room < {13'd0, w_n}) begin
                            n_stopped     = 1'b1;
                            n_sticky      = ST_TRUNC;
                            o_desc.status = ST_TRUNC;
                        end else begin
                            o_desc.cp    = i_cp[30:0];
                            o_desc.n     = w_n;
                            o_desc.addr  = r_pos;
                            o_desc.valid = 1'b1;
                            n_pos        = r_pos + {13'd0, w_n};
                        end
                    end
                end
                CMD_END: begin
                    o_push        = 1'b1;
                    o_desc.addr   = w_clip_pos;
                    o_desc.valid  = 1'b1;
                    o_desc.status = r_sticky;
                    n_stopped     = 1'b0;
                    n_sticky      = ST_OK;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size    <= 16'hffff;
            r_pos     <= 16'd0;
            r_stopped <= 1'b0;
            r_sticky  <= ST_OK;
        end else begin
            r_size    <= n_size;
            r_pos     <= n_pos;
            r_stopped <= n_stopped;
            r_sticky  <= n_sticky;
        end
    end

    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> (r_sticky == ST_TRUNC))
        else $error("stopped without truncation status");

    a_push_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (i_valid && !i_full))
        else $error("job queued without an accepted beat");

    a_begin_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_cmd == CMD_BEGIN && !i_cfg_we) |=> (r_pos < w_size))
        else $error("begin left position outside buffer");

endmodule

// File: rtl/u8ae_fifo.sv
// Small job queue between the front end and the byte emitter.
module u8ae_fifo import u8ae_pkg::*; #(
    parameter int unsigned DEPTH = FIFO_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    input  logic  i_pop,
    output t_desc o_desc,
    output logic  o_full,
    output logic  o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_desc         r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_desc  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");

endmodule

// File: rtl/u8ae_back.sv
// Back end: expands queued jobs into output bytes, one per cycle unless stalled.
module u8ae_back import u8ae_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_desc       i_desc,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_value,
    output logic [15:0] o_addr,
    output logic        o_byte_valid,
    output logic [1:0]  o_status,
    output logic        o_last
);

    logic        r_busy, n_busy;
    logic [30:0] r_cp;
    logic [2:0]  r_n;
    logic [2:0]  r_m;
    logic [15:0] r_addr;
    logic        r_bv;
    logic [1:0]  r_st;

    logic        r_ovalid;
    logic [7:0]  r_ovalue;
    logic [15:0] r_oaddr;
    logic        r_obv;
    logic [1:0]  r_ost;
    logic        r_olast;

    logic [30:0] c_cp;
    logic [2:0]  c_n;
    logic [2:0]  c_m;
    logic [15:0] c_addr;
    logic        c_bv;
    logic [1:0]  c_st;
    logic        c_avail;
    logic        w_adv;
    logic [30:0] w_sh;
    logic [7:0]  w_byte;

    assign c_cp    = r_busy ? r_cp   : i_desc.cp;
    assign c_n     = r_busy ? r_n    : i_desc.n;
    assign c_m     = r_busy ? r_m    : (i_desc.n - 3'd1);
    assign c_addr  = r_busy ? r_addr : i_desc.addr;
    assign c_bv    = r_busy ? r_bv   : i_desc.valid;
    assign c_st    = r_busy ? r_st   : i_desc.status;
    assign c_avail = r_busy || !i_empty;
    assign w_adv   = c_avail && (!r_ovalid || i_ready);
    assign o_pop   = w_adv && !r_busy;

    always_comb begin
        case (c_m)
            3'd1:    w_sh = c_cp >> 6;
            3'd2:    w_sh = c_cp >> 12;
            3'd3:    w_sh = c_cp >> 18;
            3'd4:    w_sh = c_cp >> 24;
            3'd5:    w_sh = c_cp >> 30;
            default: w_sh = c_cp;
        endcase
        if (c_m == c_n - 3'd1) begin
            w_byte = (c_n == 3'd1) ? c_cp[7:0] : (f_lead(c_n) | w_sh[7:0]);
        end else begin
            w_byte = {2'b10, w_sh[5:0]};
        end
        n_busy = r_busy;
        if (w_adv) begin
            n_busy = (c_m != 3'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cp     <= c_cp;
            r_n      <= c_n;
            r_m      <= c_m - 3'd1;
            r_addr   <= c_addr + 16'd1;
            r_bv     <= c_bv;
            r_st     <= c_st;
            r_ovalue <= w_byte;
            r_oaddr  <= c_addr;
            r_obv    <= c_bv;
            r_ost    <= c_st;
            r_olast  <= (c_m == 3'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (w_adv) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_ovalid;
    assign o_value      = r_ovalue;
    assign o_addr       = r_oaddr;
    assign o_byte_valid = r_obv;
    assign o_status     = r_ost;
    assign o_last       = r_olast;

    a_busy_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_m < r_n))
        else $error("byte index beyond job length");

    a_busy_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_ovalid) |-> !r_olast)
        else $error("last byte shown while job still running");

    a_status_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_obv) |-> (r_olast && r_ost != ST_OK))
        else $error("status-only beat malformed");

endmodule

// File: test/utf8_append_checker.sv
// Checker for the UTF-8 append encoder: predicts the byte beats of each command and compares them.
`timescale 1ns / 1ps

module utf8_append_checker import u8ae_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [47:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,
    input  logic [2:0]  i_m_tuser,
    input  logic        i_m_tlast,
    output int          o_mismatches,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0]  value;
        logic [15:0] addr;
        logic        written;
        logic [1:0]  status;
        logic        last;
    } byte_beat_t;

    byte_beat_t  expected_beats[$];
    logic [15:0] buffer_size;
    logic [15:0] write_pos;
    logic        stopped;
    logic [1:0]  sticky;

    function automatic int unsigned utf8_length(input logic [31:0] cp);
        return (cp < 32'h80) ? 1 : (cp < 32'h800) ? 2 : (cp < 32'h10000) ? 3 :
               (cp < 32'h200000) ? 4 : (cp < 32'h4000000) ? 5 : 6;
    endfunction

    task automatic queue_beat(input logic [7:0] value, input logic [15:0] addr,
                              input logic written, input logic [1:0] status,
                              input logic last);
        byte_beat_t beat;
        beat.value   = value;
        beat.addr    = addr;
        beat.written = written;
        beat.status  = status;
        beat.last    = last;
        expected_beats.push_back(beat);
    endtask

    task automatic predict_command(input logic [1:0] cmd, input logic [31:0] cp,
                                   input logic [15:0] len);
        int unsigned size;
        int unsigned room;
        int unsigned n;
        int unsigned shift;
        logic [7:0]  lead_mask;
        logic [7:0]  b;
        size = (buffer_size == 16'd0) ? 1 : buffer_size;
        case (cmd)
            CMD_BEGIN: begin
                write_pos = (len > size - 1) ? 16'(size - 1) : len;
                stopped   = 1'b0;
                sticky    = ST_OK;
            end
            CMD_ENCODE: begin
                if (stopped) begin
                    return;
                end
                if (cp[31]) begin
                    sticky = ST_NOT_CP;
                    queue_beat(8'd0, 16'd0, 1'b0, ST_NOT_CP, 1'b1);
                    return;
                end
                room = (write_pos + 1 < size) ? size - write_pos - 1 : 0;
                n    = utf8_length(cp);
                if (room < n) begin
                    stopped = 1'b1;
                    sticky  = ST_TRUNC;
                    queue_beat(8'd0, 16'd0, 1'b0, ST_TRUNC, 1'b1);
                    return;
                end
                lead_mask = 8'hff << (8 - n);
                for (int unsigned k = 0; k < n; k++) begin
                    shift = 6 * (n - 1 - k);
                    if (k == 0) begin
                        b = (n == 1) ? cp[7:0] : (lead_mask | 8'(cp >> shift));
                    end else begin
                        b = 8'h80 | 8'((cp >> shift) & 32'h3f);
                    end
                    queue_beat(b, 16'(write_pos + k), 1'b1, ST_OK, k == n - 1);
                end
                write_pos = 16'(write_pos + n);
            end
            CMD_END: begin
                queue_beat(8'd0, (write_pos > size - 1) ? 16'(size - 1) : write_pos,
                           1'b1, sticky, 1'b1);
                stopped = 1'b0;
                sticky  = ST_OK;
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        byte_beat_t want;
        if (!i_rst_n) begin
            buffer_size = 16'd65535;
            write_pos   = 16'd0;
            stopped     = 1'b0;
            sticky      = ST_OK;
            expected_beats.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                buffer_size = i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_command(i_s_tuser, i_s_tdata[31:0], i_s_tdata[47:32]);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected beat, expected none got data %h user %h last %b",
                             $time, i_m_tdata, i_m_tuser, i_m_tlast);
                    o_mismatches++;
                end else begin
                    want = expected_beats.pop_front();
                    check_field("byte_value", 16'(want.value), 16'(i_m_tdata[7:0]));
                    check_field("byte_address", want.addr, i_m_tdata[23:8]);
                    check_field("byte_valid", 16'(want.written), 16'(i_m_tuser[0]));
                    check_field("status", 16'(want.status), 16'(i_m_tuser[2:1]));
                    check_field("last", 16'(want.last), 16'(i_m_tlast));
                end
            end
        end
        o_pending = expected_beats.size();
    end

endmodule

// File: test/testbench.sv
// Top of the UTF-8 append encoder testbench: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module testbench import u8ae_pkg::*; ();

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = 16'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = 48'd0;
    logic [1:0]  s_tuser = 2'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    int          mismatches;
    int          pending;

    int          burst_left = 0;
    int          items_sent = 0;
    int unsigned cur_size = 65535;
    bit          hold_request = 1'b0;

    utf8_append_encoder u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    utf8_append_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    initial begin
        #1_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int mode;
        int stretch;
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            if (hold_request && !hold_done) begin
                @(posedge i_clk);
                m_tready <= 1'b0;
                repeat (80) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                mode    = $urandom_range(0, 3);
                stretch = $urandom_range(4, 40);
                for (int c = 0; c < stretch; c++) begin
                    @(posedge i_clk);
                    case (mode)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= 1'($urandom_range(0, 1));
                        2:       m_tready <= ($urandom_range(0, 3) == 0);
                        default: m_tready <= (c % 3 != 2);
                    endcase
                end
            end
        end
    end

    function automatic logic [31:0] random_code_point();
        case ($urandom_range(0, 6))
            0:       return $urandom_range(32'h7f, 32'h0);
            1:       return $urandom_range(32'h7ff, 32'h80);
            2:       return $urandom_range(32'hffff, 32'h800);
            3:       return $urandom_range(32'h1fffff, 32'h10000);
            4:       return $urandom_range(32'h3ffffff, 32'h200000);
            5:       return $urandom_range(32'h7fffffff, 32'h4000000);
            default: return $urandom_range(32'hffffffff, 32'h80000000);
        endcase
    endfunction

    task automatic send_beat(input logic [1:0] cmd, input logic [31:0] cp,
                             input logic [15:0] len);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {len, cp};
        s_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        burst_left--;
        if (cmd != CMD_UNUSED) begin
            items_sent++;
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_buffer_size(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        cur_size = {16'd0, value};
    endtask

    task automatic send_random_string();
        int unsigned lim;
        logic [15:0] len;
        int          count;
        lim = (cur_size == 0) ? 0 : cur_size - 1;
        case ($urandom_range(0, 7))
            0:       len = 16'($urandom_range(65534, 0));
            1:       len = 16'(lim);
            default: len = 16'($urandom_range(lim, 0));
        endcase
        if ($urandom_range(0, 7) != 0) begin
            send_beat(CMD_BEGIN, $urandom, len);
        end
        count = $urandom_range(0, 8);
        repeat (count) begin
            if ($urandom_range(0, 11) == 0) begin
                send_beat(CMD_UNUSED, $urandom, 16'($urandom));
            end else begin
                send_beat(CMD_ENCODE, random_code_point(), 16'($urandom));
            end
        end
        if ($urandom_range(0, 7) != 0) begin
            send_beat(CMD_END, $urandom, 16'($urandom));
        end
    endtask

    initial begin
        logic [31:0]  boundary_points[13];
        logic [15:0]  phase_sizes[5];
        int           phase_start;
        boundary_points = '{32'h0, 32'h7f, 32'h80, 32'h7ff, 32'h800, 32'hffff, 32'h10000,
                            32'h1fffff, 32'h200000, 32'h3ffffff, 32'h4000000,
                            32'h7fffffff, 32'hffffffff};
        phase_sizes = '{16'd65535, 16'd1, 16'($urandom_range(64, 2)),
                        16'($urandom_range(65535, 1)), 16'($urandom_range(24, 4))};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(CMD_BEGIN, 32'h0, 16'd0);
        foreach (boundary_points[i]) begin
            send_beat(CMD_ENCODE, boundary_points[i], 16'hffff);
        end
        send_beat(CMD_UNUSED, 32'hffffffff, 16'hffff);
        send_beat(CMD_END, 32'h0, 16'd0);

        wait_idle();
        write_buffer_size(16'd8);
        send_beat(CMD_BEGIN, 32'h0, 16'd3);
        send_beat(CMD_ENCODE, 32'h10000, 16'd0);
        send_beat(CMD_ENCODE, 32'h41, 16'd0);
        send_beat(CMD_ENCODE, 32'hffffffff, 16'd0);
        send_beat(CMD_END, 32'h0, 16'd0);
        send_beat(CMD_ENCODE, 32'h41, 16'd0);
        send_beat(CMD_END, 32'h0, 16'd0);

        wait_idle();
        write_buffer_size(16'd0);
        send_beat(CMD_BEGIN, 32'h0, 16'd5);
        send_beat(CMD_ENCODE, 32'h0, 16'd0);
        send_beat(CMD_END, 32'h0, 16'd0);

        wait_idle();
        write_buffer_size(16'd65535);
        send_beat(CMD_BEGIN, 32'h0, 16'd100);
        send_beat(CMD_END, 32'h0, 16'd0);
        wait_idle();
        write_buffer_size(16'd10);
        send_beat(CMD_ENCODE, 32'h41, 16'd0);
        send_beat(CMD_END, 32'h0, 16'd0);
        send_beat(CMD_BEGIN, 32'h0, 16'd65534);
        send_beat(CMD_END, 32'h0, 16'd0);

        foreach (phase_sizes[p]) begin
            wait_idle();
            write_buffer_size(phase_sizes[p]);
            phase_start = items_sent;
            if (p == 0) begin
                hold_request = 1'b1;
                send_beat(CMD_BEGIN, 32'h0, 16'd0);
                repeat (16) begin
                    send_beat(CMD_ENCODE, $urandom_range(32'h7fffffff, 32'h4000000), 16'd0);
                end
                send_beat(CMD_END, 32'h0, 16'd0);
            end
            while (items_sent - phase_start < 28) begin
                send_random_string();
            end
        end

        s_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
